// File: hdl/okls_pkg.sv
// ============================================================================
// okls_pkg: shared types and constants of the ordered key list store
// Capacity, key width, command and status codes, controller states and the
// per-cell control bundle.
// ============================================================================
`default_nettype none

package okls_pkg;

  localparam int CAPACITY  = 64;
  localparam int KEY_WIDTH = 64;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_DUMP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_ABSENT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_APPLY,
    S_DUMP
  } state_t;

  // What a cell loads at the next edge. At most one bit is set.
  typedef struct packed {
    logic load_key;    // take the appended key
    logic take_right;  // take the key of the next cell toward the tail
    logic take_head;   // take the key of the head cell (dump rotation)
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: hdl/okls_cell.sv
// ============================================================================
// okls_cell: one entry of the key chain
// Holds a single key, compares it against the lookup key and loads from its
// neighbor, from the head cell or from the append key as it is told.
// ============================================================================
`default_nettype none

module okls_cell (
  input  wire logic                          clk,
  input  wire okls_pkg::cell_ctrl_t          ctrl,
  input  wire logic                          occupied,
  input  wire logic [okls_pkg::KEY_WIDTH-1:0] right_key,
  input  wire logic [okls_pkg::KEY_WIDTH-1:0] head_key,
  input  wire logic [okls_pkg::KEY_WIDTH-1:0] new_key,
  input  wire logic [okls_pkg::KEY_WIDTH-1:0] cmp_key,
  output logic      [okls_pkg::KEY_WIDTH-1:0] entry,
  output logic                               hit
);
  import okls_pkg::*;

  // The entry holds payload only; whether it is in use comes from the count.
  always_ff @(posedge clk) begin
    if (ctrl.load_key) begin
      entry <= new_key;
    end else if (ctrl.take_right) begin
      entry <= right_key;
    end else if (ctrl.take_head) begin
      entry <= head_key;
    end
  end

  assign hit = occupied && (entry == cmp_key);

endmodule

`default_nettype wire

// File: hdl/ordered_key_list_store_top.sv
// ============================================================================
// ordered_key_list_store_top: bounded ordered key list
// A chain of key cells with a small controller for append, remove, search
// and dump; results come as strobed items on a result port, one per cycle in a dump.
// ============================================================================
//
// Usage:
//   An item (cmd, key) is taken at a rising edge where start is high and busy
//   is low. Each result item is shown for exactly one cycle with done high;
//   the receiver cannot stall, so results are never held back.
// Command flow:
//   Append, remove and search: all cells compare their key with the incoming
//   key in the accept cycle and the hit vector is registered. In the next
//   cycle the chain is updated and the result and done are registered.
//   busy falls together with done, so a new item is taken only once the
//   previous result has been registered.
//   Dump of N stored keys: the chain rotates one place toward the head each
//   cycle and the head key is emitted, so the N results follow on
//   consecutive cycles; after N steps the list is back in its original
//   order. An empty dump yields a single result. busy stays high until the
//   last dump result is registered.
// Remove closes the gap in one step: every cell at or behind the first match
//   takes its tail-side neighbor's key.
// Reset (synchronous, active high) empties the list and clears busy and
//   done; cell contents are left as they are and are only read below the
//   entry count.
// ============================================================================
`default_nettype none

module ordered_key_list_store_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    cmd,
  input  wire logic [63:0]                   key,
  output logic                               done,
  output logic                               found,
  output logic [1:0]                         status,
  output logic [6:0]                         entry_count,
  output logic [63:0]                        dump_value,
  output logic                               value_valid,
  output logic                               last
);
  import okls_pkg::*;

  state_t                   state, state_next;
  logic [CNT_W-1:0]         count, count_next;
  logic [IDX_W-1:0]         idx, idx_next;
  cmd_t                     cmd_q;
  logic [KEY_WIDTH-1:0]     key_q;
  logic [CAPACITY-1:0]      hits;
  logic [CAPACITY-1:0]      hit_vec;
  logic [CAPACITY-1:0]      seen;
  logic [KEY_WIDTH-1:0]     entries [CAPACITY];
  cell_ctrl_t               ctrl [CAPACITY];
  logic                     accept;
  logic                     any_hit;
  logic                     dump_last;
  logic                     res_fire;
  logic                     res_found;
  status_t                  res_status;
  logic [KEY_WIDTH-1:0]     res_value;
  logic                     res_valid;
  logic                     res_last;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // --------------------------------------------------------------------------
  // Cell chain. The incoming key is compared directly so the hit vector is
  // ready at the accept edge.
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_WIDTH-1:0] right;
    if (i == CAPACITY - 1) begin : g_tail
      assign right = entries[i];
    end else begin : g_mid
      assign right = entries[i + 1];
    end

    okls_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl[i]),
      .occupied  (CNT_W'(i) < count),
      .right_key (right),
      .head_key  (entries[0]),
      .new_key   (key_q),
      .cmp_key   (key[KEY_WIDTH-1:0]),
      .entry     (entries[i]),
      .hit       (hit_vec[i])
    );
  end

  // Prefix OR of the hit vector: a cell is at or behind the first match.
  always_comb begin
    seen = hits;
    for (int s = 1; s < CAPACITY; s = s * 2) begin
      seen = seen | (seen << s);
    end
  end

  assign any_hit   = |hits;
  assign dump_last = ({1'b0, idx} == (count - CNT_W'(1)));

  // --------------------------------------------------------------------------
  // Registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= res_fire;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (accept) begin
      cmd_q <= cmd_t'(cmd);
      key_q <= key[KEY_WIDTH-1:0];
      hits  <= hit_vec;
    end
    if (res_fire) begin
      found       <= res_found;
      status      <= res_status;
      entry_count <= 7'(count_next);
      dump_value  <= 64'(res_value);
      value_valid <= res_valid;
      last        <= res_last;
    end
  end

  // --------------------------------------------------------------------------
  // Next state.
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if ((cmd_t'(cmd) == CMD_DUMP) && (count != '0)) begin
            state_next = S_DUMP;
          end else begin
            state_next = S_APPLY;
          end
        end
      end
      S_APPLY: begin
        state_next = S_IDLE;
      end
      S_DUMP: begin
        if (dump_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Outputs: chain control, count update and result.
  // --------------------------------------------------------------------------
  always_comb begin
    count_next = count;
    idx_next   = idx;
    res_fire   = 1'b0;
    res_found  = 1'b0;
    res_status = STAT_OK;
    res_value  = '0;
    res_valid  = 1'b0;
    res_last   = 1'b1;
    for (int i = 0; i < CAPACITY; i++) begin
      ctrl[i] = '0;
    end

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          idx_next = '0;
        end
      end
      S_APPLY: begin
        res_fire = 1'b1;
        case (cmd_q)
          CMD_APPEND: begin
            if (count == CNT_W'(CAPACITY)) begin
              res_status = STAT_FULL;
            end else begin
              count_next = count + CNT_W'(1);
              for (int i = 0; i < CAPACITY; i++) begin
                ctrl[i].load_key = (count == CNT_W'(i));
              end
            end
          end
          CMD_REMOVE: begin
            if (any_hit) begin
              res_found  = 1'b1;
              count_next = count - CNT_W'(1);
              for (int i = 0; i < CAPACITY; i++) begin
                ctrl[i].take_right = seen[i];
              end
            end else begin
              res_status = STAT_ABSENT;
            end
          end
          CMD_SEARCH: begin
            if (any_hit) begin
              res_found = 1'b1;
            end else begin
              res_status = STAT_ABSENT;
            end
          end
          default: begin
            // Dump of an empty list: a single result with nothing in it.
          end
        endcase
      end
      S_DUMP: begin
        res_fire  = 1'b1;
        res_value = entries[0];
        res_valid = 1'b1;
        res_last  = dump_last;
        idx_next  = idx + IDX_W'(1);
        // Rotate the occupied part of the chain one place toward the head.
        for (int i = 0; i < CAPACITY; i++) begin
          if (CNT_W'(i) == (count - CNT_W'(1))) begin
            ctrl[i].take_head = 1'b1;
          end else begin
            ctrl[i].take_right = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// File: tb/okls_checker.sv
// ============================================================================
// okls_checker: result checker for the ordered key list store
// Watches the command and result ports, keeps a shadow copy of the key list,
// predicts every result item and compares each one field by field.
// ============================================================================

module okls_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [1:0]  cmd,
  input  wire logic [63:0] key,
  input  wire logic        done,
  input  wire logic        found,
  input  wire logic [1:0]  status,
  input  wire logic [6:0]  entry_count,
  input  wire logic [63:0] dump_value,
  input  wire logic        value_valid,
  input  wire logic        last,
  output int               mismatches,
  output int               outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import okls_pkg::*;

  typedef struct packed {
    logic                 found;
    status_t              status;
    logic [6:0]           entry_count;
    logic [KEY_WIDTH-1:0] dump_value;
    logic                 value_valid;
    logic                 last;
  } list_result_t;

  logic [KEY_WIDTH-1:0] shadow_keys[$];
  list_result_t         pending_results[$];

  // Updates the shadow list for one command and queues the results it causes.
  function automatic void apply_command(input cmd_t op, input logic [63:0] raw_key);
    logic [KEY_WIDTH-1:0] k;
    int                   hit;
    list_result_t         r;
    k   = raw_key[KEY_WIDTH-1:0];
    hit = -1;
    for (int i = 0; i < shadow_keys.size() && hit < 0; i++) begin
      if (shadow_keys[i] == k) hit = i;
    end
    r      = '0;
    r.last = 1'b1;
    case (op)
      CMD_APPEND: begin
        if (shadow_keys.size() >= CAPACITY) r.status = STAT_FULL;
        else shadow_keys.push_back(k);
      end
      CMD_REMOVE: begin
        if (hit < 0) begin
          r.status = STAT_ABSENT;
        end else begin
          shadow_keys.delete(hit);
          r.found = 1'b1;
        end
      end
      CMD_SEARCH: begin
        if (hit < 0) r.status = STAT_ABSENT;
        else r.found = 1'b1;
      end
      default: begin
        // A dump of a non-empty list yields one item per entry, in order.
        for (int i = 0; i < shadow_keys.size(); i++) begin
          r.dump_value  = shadow_keys[i];
          r.value_valid = 1'b1;
          r.entry_count = 7'(shadow_keys.size());
          r.last        = (i == shadow_keys.size() - 1);
          pending_results.push_back(r);
        end
      end
    endcase
    if (op != CMD_DUMP || shadow_keys.size() == 0) begin
      r.entry_count = 7'(shadow_keys.size());
      pending_results.push_back(r);
    end
  endfunction

  function automatic void compare_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      shadow_keys.delete();
      pending_results.delete();
    end else begin
      if (done) begin
        if (pending_results.size() == 0) begin
          $error("result item with nothing expected");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          compare_field("found", 64'(want.found), 64'(found));
          compare_field("status", 64'(want.status), 64'(status));
          compare_field("entry_count", 64'(want.entry_count), 64'(entry_count));
          compare_field("dump_value", 64'(want.dump_value), dump_value);
          compare_field("value_valid", 64'(want.value_valid), 64'(value_valid));
          compare_field("last", 64'(want.last), 64'(last));
        end
      end
      if (start && !busy) apply_command(cmd_t'(cmd), key);
    end
    outstanding = pending_results.size();
  end

endmodule

// File: tb/tb_top.sv
// ============================================================================
// tb_top: testbench for the ordered key list store
// Drives append, remove, search and dump commands, first a directed list and
// then random phases with varied sender idling; a checker beside the block
// predicts and compares every result item and reports failures here.
// ============================================================================

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import okls_pkg::*;

  // Cycles without any accepted command or result before the run is called hung.
  localparam int QUIET_LIMIT = 2000;
  localparam int POOL_SIZE   = 12;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  cmd = CMD_APPEND;
  logic [63:0] key = '0;

  logic        busy;
  logic        done;
  logic        found;
  logic [1:0]  status;
  logic [6:0]  entry_count;
  logic [63:0] dump_value;
  logic        value_valid;
  logic        last;

  int          mismatches;
  int          outstanding;
  int          idle_pct = 0;
  int          quiet_cycles = 0;

  // A small pool of recently used keys, so that removes and searches hit
  // stored entries and duplicates end up in the list.
  logic [63:0] key_pool[POOL_SIZE];

  ordered_key_list_store_top uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .key(key),
    .done(done), .found(found), .status(status), .entry_count(entry_count),
    .dump_value(dump_value), .value_valid(value_valid), .last(last)
  );

  okls_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .key(key),
    .done(done), .found(found), .status(status), .entry_count(entry_count),
    .dump_value(dump_value), .value_valid(value_valid), .last(last),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  always #4 clk = ~clk;

  // The watchdog restarts whenever an item is accepted or a result appears.
  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Key choice: mostly pool keys, some extremes, some fresh random values.
  // Fresh values sometimes replace a pool entry so the pool keeps moving.
  function automatic logic [63:0] pick_key();
    int          roll;
    logic [63:0] k;
    roll = $urandom_range(99);
    if (roll < 55) return key_pool[$urandom_range(POOL_SIZE - 1)];
    if (roll < 65) begin
      case ($urandom_range(3))
        0: return 64'd0;
        1: return '1;
        2: return 64'd1;
        default: return 64'h8000_0000_0000_0000;
      endcase
    end
    k = {$urandom, $urandom};
    if ($urandom_range(99) < 30) key_pool[$urandom_range(POOL_SIZE - 1)] = k;
    return k;
  endfunction

  // A filling phase favors appends, a draining phase favors removes.
  function automatic cmd_t pick_op(input bit filling);
    int roll;
    roll = $urandom_range(99);
    if (roll < (filling ? 50 : 15)) return CMD_APPEND;
    if (roll < 65) return CMD_REMOVE;
    if (roll < 90) return CMD_SEARCH;
    return CMD_DUMP;
  endfunction

  // Called at a falling edge. Presents one item and holds it until the block
  // takes it; busy read just after the rising edge is its value at that edge.
  // Then, depending on the idle rate, the sender leaves start low for a few
  // cycles with noise on the command and key lines.
  task automatic issue(input cmd_t op, input logic [63:0] k);
    start = 1'b1;
    cmd   = op;
    key   = k;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    if ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      cmd   = 2'($urandom);
      key   = {$urandom, $urandom};
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  // Holds the sender off until every expected result item has come back.
  task automatic wait_drained();
    start = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    int phase_idle[4];
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    phase_idle[0] = 0;
    phase_idle[1] = 65;
    phase_idle[2] = 0;
    phase_idle[3] = 18;

    repeat (2) @(negedge clk);
    rst = 1'b0;

    // Directed part. Starts on the empty list: dump, search and remove of an
    // absent key. Then a list with a duplicate key is built so that remove
    // has to pick the first match, and entries go from the head, the middle
    // and the tail until the list is empty again.
    issue(CMD_DUMP, 64'd0);
    issue(CMD_SEARCH, 64'd0);
    issue(CMD_REMOVE, '1);
    issue(CMD_APPEND, 64'd0);
    issue(CMD_APPEND, '1);
    issue(CMD_APPEND, 64'h5555_5555_5555_5555);
    issue(CMD_APPEND, 64'hAAAA_AAAA_AAAA_AAAA);
    issue(CMD_APPEND, 64'd0);
    issue(CMD_SEARCH, '1);
    issue(CMD_SEARCH, 64'd1);
    issue(CMD_REMOVE, 64'd0);
    issue(CMD_DUMP, '1);
    issue(CMD_REMOVE, 64'h5555_5555_5555_5555);
    issue(CMD_REMOVE, 64'd0);
    issue(CMD_REMOVE, 64'd0);
    issue(CMD_DUMP, 64'h1234);
    issue(CMD_REMOVE, '1);
    issue(CMD_REMOVE, 64'hAAAA_AAAA_AAAA_AAAA);
    issue(CMD_SEARCH, 64'hAAAA_AAAA_AAAA_AAAA);
    issue(CMD_DUMP, 64'd0);
    issue(CMD_APPEND, 64'h8000_0000_0000_0001);
    issue(CMD_DUMP, 64'd0);
    wait_drained();

    // Random phases with different sender idle rates. The phase with heavy
    // idling opens with a burst of appends that runs past capacity, so that
    // full rejections are seen and a dump of the full list follows.
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = phase_idle[phase];
      if (phase == 1) begin
        repeat (CAPACITY + 2) issue(CMD_APPEND, pick_key());
        issue(CMD_SEARCH, pick_key());
        issue(CMD_DUMP, pick_key());
      end
      repeat (70) issue(pick_op(phase % 2 == 0), pick_key());
      wait_drained();
    end

    // Nothing more to send: let the last results arrive, then a few more
    // cycles so that a stray extra result would still be caught.
    start = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/okls_pkg.sv
hdl/okls_cell.sv
hdl/ordered_key_list_store_top.sv
tb/okls_checker.sv
tb/tb_top.sv
